@@ rtl/ipls_pkg.sv @@
// shared types and constants for the indexed point list store
// no dependencies; imported by ipls_seq and the top level, not by the point ram
package ipls_pkg;

    // fixed field widths of the stream words
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int COORD_W = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // packed field widths, and stream word widths rounded up to whole bytes
    localparam int IN_FIELDS_W  = OP_W + POS_W + 3 * COORD_W;
    localparam int OUT_FIELDS_W = STAT_W + 3 * COORD_W + COUNT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // parameter defaults
    localparam int CAPACITY_DEF   = 64;
    localparam int COORD_BITS_DEF = 32;

    // request opcodes; other codes change nothing and return an ok result
    typedef enum logic [OP_W-1:0] {
        OP_INSERT       = 3'd0,
        OP_APPEND       = 3'd1,
        OP_REMOVE_FIRST = 3'd2,
        OP_REMOVE_LAST  = 3'd3,
        OP_READ         = 3'd4
    } t_opcode;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BOUNDS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

    // one request word
    typedef struct packed {
        logic signed [COORD_W-1:0] coord_z;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_x;
        logic [POS_W-1:0]          position;
        logic [OP_W-1:0]           opcode;
    } t_request;

    // one result word
    typedef struct packed {
        logic [COUNT_W-1:0]        entry_count;
        logic signed [COORD_W-1:0] read_z;
        logic signed [COORD_W-1:0] read_y;
        logic signed [COORD_W-1:0] read_x;
        t_status                   status;
    } t_result;

endpackage

@@ rtl/ipls_point_ram.sv @@
// point storage: one write port, one read port, registered read data
// depends on no package; sized by its parameters
module ipls_point_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ipls_seq.sv @@
// request sequencer: decode, ring-buffer addressing, insert shift loop, count
// depends on ipls_pkg; drives the point ram ports
module ipls_seq #(
    parameter int CAPACITY   = ipls_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = ipls_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  ipls_pkg::t_request            i_req,
    // result side
    input  logic                          i_res_ready,
    output logic                          o_res_valid,
    output ipls_pkg::t_result             o_res,
    // point ram
    output logic                          o_ram_we,
    output logic [$clog2(CAPACITY)-1:0]   o_ram_waddr,
    output logic [3*COORD_BITS-1:0]       o_ram_wdata,
    output logic                          o_ram_re,
    output logic [$clog2(CAPACITY)-1:0]   o_ram_raddr,
    input  logic [3*COORD_BITS-1:0]       i_ram_rdata
);
    import ipls_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int PW    = 3 * COORD_BITS;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]    r_head,  n_head;
    logic [AW-1:0]    r_idx,   n_idx;
    logic [AW-1:0]    r_pos,   n_pos;
    logic [PW-1:0]    r_point, n_point;
    t_status          r_status, n_status;
    logic             r_is_read, n_is_read;

    logic [CMP_W-1:0]       w_pos_c;
    logic [CMP_W-1:0]       w_cnt_c;
    logic                   w_full;
    logic                   w_empty;
    logic [PW-1:0]          w_req_point;
    logic signed [COORD_BITS-1:0] w_rd_x, w_rd_y, w_rd_z;
    logic [CNT_W+COUNT_W-1:0] w_cnt_ext;

    // logical index to ram address around the ring head
    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    // request decode helpers
    assign w_pos_c     = CMP_W'(i_req.position);
    assign w_cnt_c     = CMP_W'(r_count);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_req_point = {i_req.coord_z[COORD_BITS-1:0], i_req.coord_y[COORD_BITS-1:0],
                          i_req.coord_x[COORD_BITS-1:0]};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    // request payload and result flags
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_point   <= n_point;
        r_status  <= n_status;
        r_is_read <= n_is_read;
    end

    // next state, ram control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_point     = r_point;
        n_status    = r_status;
        n_is_read   = r_is_read;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = r_point;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_point   = w_req_point;
                    n_status  = ST_OK;
                    n_is_read = 1'b0;
                    n_state   = S_DONE;
                    unique case (i_req.opcode)
                        OP_INSERT: begin
                            if (w_pos_c > w_cnt_c) begin
                                n_status = ST_BOUNDS;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else if (w_pos_c == w_cnt_c) begin
                                // insert at the end needs no shift
                                o_ram_we    = 1'b1;
                                o_ram_waddr = f_wrap(r_head, r_count[AW-1:0]);
                                o_ram_wdata = w_req_point;
                                n_count     = r_count + CNT_W'(1);
                            end else begin
                                // start moving the tail up from the last entry
                                n_pos       = w_pos_c[AW-1:0];
                                n_idx       = r_count[AW-1:0] - AW'(1);
                                o_ram_re    = 1'b1;
                                o_ram_raddr = f_wrap(r_head, r_count[AW-1:0] - AW'(1));
                                n_state     = S_SHIFT;
                            end
                        end
                        OP_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = f_wrap(r_head, r_count[AW-1:0]);
                                o_ram_wdata = w_req_point;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        OP_REMOVE_FIRST: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_head  = f_wrap(r_head, AW'(1));
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_REMOVE_LAST: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_READ: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos_c >= w_cnt_c) begin
                                n_status = ST_BOUNDS;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = f_wrap(r_head, w_pos_c[AW-1:0]);
                                n_is_read   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // entry r_idx arrived: move it one place up
                o_ram_we    = 1'b1;
                o_ram_waddr = f_wrap(r_head, r_idx + AW'(1));
                o_ram_wdata = i_ram_rdata;
                if (r_idx == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    n_idx       = r_idx - AW'(1);
                    o_ram_re    = 1'b1;
                    o_ram_raddr = f_wrap(r_head, r_idx - AW'(1));
                end
            end
            S_PUT: begin
                // new point into the freed slot
                o_ram_we    = 1'b1;
                o_ram_waddr = f_wrap(r_head, r_pos);
                o_ram_wdata = r_point;
                n_count     = r_count + CNT_W'(1);
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result word; read data stays in the ram output register until done
    assign w_rd_x    = i_ram_rdata[COORD_BITS-1:0];
    assign w_rd_y    = i_ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign w_rd_z    = i_ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_cnt_ext = (CNT_W+COUNT_W)'(r_count);

    always_comb begin
        o_res.status      = r_status;
        o_res.read_x      = r_is_read ? COORD_W'(w_rd_x) : '0;
        o_res.read_y      = r_is_read ? COORD_W'(w_rd_y) : '0;
        o_res.read_z      = r_is_read ? COORD_W'(w_rd_z) : '0;
        o_res.entry_count = w_cnt_ext[COUNT_W-1:0];
    end

    // count never passes capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // the shift loop never runs below the insert position
    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_idx >= r_pos))
        else $error("shift index below insert position");

    // a read and a write in the same cycle never hit the same entry
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && o_ram_re) |-> (o_ram_waddr != o_ram_raddr))
        else $error("ram read and write to the same entry");

    // a delivered result returns the sequencer to idle
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_state == S_IDLE))
        else $error("sequencer not idle after result");

    // a read request, successful or not, leaves the count unchanged
    a_read_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_valid && i_req.opcode == OP_READ)
        |=> (r_count == $past(r_count)))
        else $error("read changed the entry count");

endmodule

@@ rtl/indexed_point_list_store.sv @@
// indexed point list store: top level with stream ports and result register
// depends on ipls_pkg, ipls_seq and ipls_point_ram
//
//   channel   | dir | word
//   ----------+-----+-------------------------------------------------------
//   s_axis    | in  | opcode, position, coord_x, coord_y, coord_z
//   m_axis    | out | status, read_x, read_y, read_z, entry_count
//
// append, removals, reads, errors and insert at the end: decode in idle, then the done state
// insert inside the list: shift loop, then put, then done; one entry moved per
//   cycle through the single write port of the point ram
// removal of the first entry moves the ring head, no data is copied
// reset (synchronous, active low) clears the count and head; ram is not cleared
// a new word is taken while the previous result waits in the output register
module indexed_point_list_store #(
    parameter int CAPACITY   = ipls_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = ipls_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // opcode[2:0], position[9:3], coord_x[41:10], coord_y[73:42], coord_z[105:74]
    input  logic [ipls_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // status[1:0], read_x[33:2], read_y[65:34], read_z[97:66], entry_count[104:98]
    output logic [ipls_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import ipls_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = 3 * COORD_BITS;

    t_request         w_req;
    t_result          w_res;
    logic             w_res_valid;
    logic             w_res_ready;
    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    logic [PW-1:0]    w_ram_wdata;
    logic             w_ram_re;
    logic [AW-1:0]    w_ram_raddr;
    logic [PW-1:0]    w_ram_rdata;

    logic                   r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;

    // unpack request word
    assign w_req = i_s_axis_tdata[IN_FIELDS_W-1:0];

    // output register free or draining this cycle
    assign w_res_ready = !r_m_tvalid || i_m_axis_tready;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_res_valid) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_m_tdata <= OUT_TDATA_W'(w_res);
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

    ipls_seq #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req       (w_req),
        .i_res_ready (w_res_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    ipls_point_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule
